// ----- rtl/ttlk_pkg.sv -----
`default_nettype none
package ttlk_pkg;

  localparam logic [2:0] ACT_PUT    = 3'd0;
  localparam logic [2:0] ACT_REVEAL = 3'd1;
  localparam logic [2:0] ACT_EXPIRE = 3'd2;
  localparam logic [2:0] ACT_ERASE  = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic       REG_MAX_ENTRIES = 1'b0;
  localparam logic       REG_LIFETIME    = 1'b1;

  localparam logic [6:0]  MAX_ENTRIES_RST = 7'd64;
  localparam logic [31:0] LIFETIME_DEF    = 32'd300;

  typedef enum logic [2:0] {
    SM_PUT,
    SM_REVEAL,
    SM_EXPIRE,
    SM_ERASE,
    SM_OLDEST
  } scan_mode_t;

  typedef struct packed {
    logic       capture;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       put_write;
    logic       evict_drop;
    logic       clear_all;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic over_limit;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/ttlk_ram.sv -----
`default_nettype none
module ttlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/ttlk_ctrl.sv -----
`default_nettype none
module ttlk_ctrl
  import ttlk_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_action,
  output logic            out_valid,
  input  wire logic       out_stall,
  output dp_cmd_t         cmd,
  input  wire dp_sts_t    sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_PUT_WR,
    S_EVCHK,
    S_EVICT,
    S_DROP,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] op_r;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign acc       = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.scan_mode = SM_PUT;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        state_nxt = S_SCAN;
        case (op_r)
          ACT_PUT:    begin cmd.scan_start = 1'b1; cmd.scan_mode = SM_PUT;    end
          ACT_REVEAL: begin cmd.scan_start = 1'b1; cmd.scan_mode = SM_REVEAL; end
          ACT_EXPIRE: begin cmd.scan_start = 1'b1; cmd.scan_mode = SM_EXPIRE; end
          ACT_ERASE:  begin cmd.scan_start = 1'b1; cmd.scan_mode = SM_ERASE;  end
          ACT_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_nxt     = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = (op_r == ACT_PUT) ? S_PUT_WR : S_OUT;
        end
      end
      S_PUT_WR: begin
        cmd.put_write = 1'b1;
        state_nxt     = S_EVCHK;
      end
      S_EVCHK: begin
        if (sts.over_limit) begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode  = SM_OLDEST;
          state_nxt      = S_EVICT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_EVICT: begin
        // oldest tracker settles on the edge that ends the walk
        if (sts.scan_done) begin
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        cmd.evict_drop = 1'b1;
        state_nxt      = S_EVCHK;
      end
      S_OUT: begin
        // result register must be free before the next beat goes out
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= ACT_PUT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        op_r <= in_action;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ttlk_dp.sv -----
`default_nettype none
module ttlk_dp
  import ttlk_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_request_key,
  input  wire logic [31:0] in_item_key,
  input  wire logic [7:0]  in_category_in,
  input  wire logic [63:0] in_payload_in,
  input  wire logic [31:0] in_now_time,
  output logic             out_found,
  output logic [7:0]       out_category_out,
  output logic [63:0]      out_payload_out,
  output logic [31:0]      out_remaining_time,
  output logic [63:0]      out_audit_sequence,
  output logic [6:0]       out_removed_count,
  output logic [6:0]       out_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KB = KEY_BITS;
  localparam int PB = PAYLOAD_BITS;
  // entry word, low to high: sequence, expiry, payload, category, item, request
  localparam int SEQ_LO = 0;
  localparam int EXP_LO = 64;
  localparam int PAY_LO = EXP_LO + 33;
  localparam int CAT_LO = PAY_LO + PB;
  localparam int IK_LO  = CAT_LO + 8;
  localparam int RK_LO  = IK_LO + KB;
  localparam int EW     = RK_LO + KB;

  // config
  logic [6:0]  max_r;
  logic [31:0] life_r;

  // captured request
  logic [2:0]    op_r;
  logic [KB-1:0] rk_r, ik_r;
  logic [7:0]    cat_r;
  logic [PB-1:0] pay_r;
  logic [31:0]   now_r;

  logic [CAPACITY-1:0] vld_r;
  logic [CW-1:0]       live_r;
  logic [CW-1:0]       removed_r;
  logic [63:0]         seq_r;

  // scan
  scan_mode_t   mode_r;
  logic         scan_on_r;
  logic [AW:0]  iss_cnt_r;
  logic         p_vld_r;
  logic [AW-1:0] p_idx_r;

  // trackers
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [7:0]    hit_cat_r;
  logic [PB-1:0] hit_pay_r;
  logic [32:0]   hit_exp_r;
  logic [63:0]   hit_seq_r;
  logic          free_f_r;
  logic [AW-1:0] free_idx_r;
  logic          old_f_r;
  logic [AW-1:0] old_idx_r;
  logic [63:0]   old_seq_r;

  // ram
  logic [EW-1:0] rd_data, wr_data;
  logic [AW-1:0] wr_addr, rd_addr;

  logic [63:0]   rk_ext, ik_ext;
  logic [KB-1:0] e_rk, e_ik;
  logic [7:0]    e_cat;
  logic [PB-1:0] e_pay;
  logic [32:0]   e_exp;
  logic [63:0]   e_seq;
  logic          e_v, key_eq, expired, older, do_drop, count_drop;
  logic [31:0]   life_eff, lim32, live32;
  logic [32:0]   new_exp;
  logic          full;
  logic [32:0]   rem_diff;
  logic [15:0]   live16, rem16;

  assign rk_ext = {32'd0, in_request_key};
  assign ik_ext = {32'd0, in_item_key};

  assign e_seq = rd_data[SEQ_LO +: 64];
  assign e_exp = rd_data[EXP_LO +: 33];
  assign e_pay = rd_data[PAY_LO +: PB];
  assign e_cat = rd_data[CAT_LO +: 8];
  assign e_ik  = rd_data[IK_LO +: KB];
  assign e_rk  = rd_data[RK_LO +: KB];

  assign e_v     = p_vld_r && vld_r[p_idx_r];
  assign key_eq  = (e_rk == rk_r) && (e_ik == ik_r);
  assign expired = (e_exp <= {1'b0, now_r});
  assign older   = !old_f_r || (e_seq < old_seq_r);

  always_comb begin
    do_drop    = 1'b0;
    count_drop = 1'b0;
    case (mode_r)
      SM_REVEAL: do_drop = e_v && expired;
      SM_EXPIRE: begin do_drop = e_v && expired; count_drop = do_drop; end
      SM_ERASE:  begin do_drop = e_v && (e_rk == rk_r); count_drop = do_drop; end
      default:   do_drop = 1'b0;
    endcase
  end

  assign life_eff = (life_r == 32'd0) ? LIFETIME_DEF : life_r;
  assign new_exp  = {1'b0, now_r} + {1'b0, life_eff};
  assign live32   = 32'(live_r);
  assign lim32    = ((max_r == 7'd0) || (32'(max_r) > CAPACITY)) ? 32'(CAPACITY)
                                                                 : 32'(max_r);
  assign full     = (live32 >= CAPACITY);

  assign sts.scan_done  = p_vld_r && (32'(p_idx_r) == CAPACITY - 1);
  assign sts.over_limit = (live32 > lim32);

  always_comb begin
    if (hit_r) begin
      wr_addr = hit_idx_r;
    end else if (full) begin
      wr_addr = old_idx_r;
    end else begin
      wr_addr = free_idx_r;
    end
  end

  assign wr_data = {rk_r, ik_r, cat_r, pay_r, new_exp, seq_r};
  assign rd_addr = iss_cnt_r[AW-1:0];

  ttlk_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.put_write),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= MAX_ENTRIES_RST;
      life_r    <= LIFETIME_DEF;
      vld_r     <= '0;
      live_r    <= '0;
      removed_r <= '0;
      seq_r     <= '0;
      mode_r    <= SM_PUT;
      scan_on_r <= 1'b0;
      iss_cnt_r <= '0;
      p_vld_r   <= 1'b0;
      hit_r     <= 1'b0;
      free_f_r  <= 1'b0;
      old_f_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_ENTRIES: max_r  <= cfg_wdata[6:0];
          REG_LIFETIME:    life_r <= cfg_wdata;
          default:         max_r  <= max_r;
        endcase
      end

      if (cmd.capture) begin
        removed_r <= '0;
        hit_r     <= 1'b0;
      end

      // address issue
      p_vld_r <= scan_on_r && !cmd.scan_start;
      if (cmd.scan_start) begin
        mode_r    <= cmd.scan_mode;
        scan_on_r <= 1'b1;
        iss_cnt_r <= '0;
        hit_r     <= 1'b0;
        free_f_r  <= 1'b0;
        old_f_r   <= 1'b0;
      end else if (scan_on_r) begin
        iss_cnt_r <= iss_cnt_r + 1'b1;
        if (32'(iss_cnt_r) == CAPACITY - 1) begin
          scan_on_r <= 1'b0;
        end
      end

      // one slot per cycle
      if (p_vld_r) begin
        if (e_v && older) begin
          old_f_r <= 1'b1;
        end
        if (mode_r == SM_PUT && !vld_r[p_idx_r] && !free_f_r) begin
          free_f_r <= 1'b1;
        end
        if ((mode_r == SM_PUT || mode_r == SM_REVEAL) && e_v && !do_drop && key_eq
            && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (do_drop) begin
          vld_r[p_idx_r] <= 1'b0;
          live_r         <= live_r - 1'b1;
        end
        if (count_drop) begin
          removed_r <= removed_r + 1'b1;
        end
      end

      if (cmd.put_write) begin
        vld_r[wr_addr] <= 1'b1;
        seq_r          <= seq_r + 64'd1;
        if (!hit_r && !full) begin
          live_r <= live_r + 1'b1;
        end
      end

      if (cmd.evict_drop) begin
        vld_r[old_idx_r] <= 1'b0;
        live_r           <= live_r - 1'b1;
      end

      if (cmd.clear_all) begin
        vld_r  <= '0;
        live_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_action;
      rk_r  <= rk_ext[KB-1:0];
      ik_r  <= ik_ext[KB-1:0];
      cat_r <= in_category_in;
      pay_r <= in_payload_in[PB-1:0];
      now_r <= in_now_time;
    end
    if (p_vld_r) begin
      if (e_v && older) begin
        old_idx_r <= p_idx_r;
        old_seq_r <= e_seq;
      end
      if (mode_r == SM_PUT && !vld_r[p_idx_r] && !free_f_r) begin
        free_idx_r <= p_idx_r;
      end
      if ((mode_r == SM_PUT || mode_r == SM_REVEAL) && e_v && !do_drop && key_eq
          && !hit_r) begin
        hit_idx_r <= p_idx_r;
        hit_cat_r <= e_cat;
        hit_pay_r <= e_pay;
        hit_exp_r <= e_exp;
        hit_seq_r <= e_seq;
      end
    end
    if (scan_on_r && !cmd.scan_start) begin
      p_idx_r <= iss_cnt_r[AW-1:0];
    end
  end

  // result register
  assign rem_diff = hit_exp_r - {1'b0, now_r};
  assign live16   = 16'(live_r);
  assign rem16    = 16'(removed_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (op_r == ACT_REVEAL && hit_r) begin
        out_found          <= 1'b1;
        out_category_out   <= hit_cat_r;
        out_payload_out    <= 64'(hit_pay_r);
        out_audit_sequence <= hit_seq_r;
        if (hit_exp_r > {1'b0, now_r}) begin
          out_remaining_time <= rem_diff[32] ? 32'hFFFF_FFFF : rem_diff[31:0];
        end else begin
          out_remaining_time <= 32'd0;
        end
      end else begin
        out_found          <= 1'b0;
        out_category_out   <= 8'd0;
        out_payload_out    <= 64'd0;
        out_audit_sequence <= 64'd0;
        out_remaining_time <= 32'd0;
      end
      out_removed_count <= rem16[6:0];
      out_entry_count   <= live16[6:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ttl_keyed_table_oldest_evict.sv -----
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   action, keys, category, payload, now
// out      from block out_valid / out_stall found, data, times, counts
// cfg      to block   cfg_we                cfg_index, cfg_wdata
//
// put, reveal, expire and erase walk all CAPACITY slots through the entry ram, one slot a cycle
// expire, erase, reveal: one walk, then the result beat
// put: one walk and the entry write, plus another walk for each oldest entry evicted
// clear and unknown codes: no walk
// reset (rst_n low, synchronous) empties the table; no clearing pass is needed
// a finished op waits while the previous result beat stalls, then frees the input
`default_nettype none
module ttl_keyed_table_oldest_evict
  import ttlk_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_request_key,
  input  wire logic [31:0] in_item_key,
  input  wire logic [7:0]  in_category_in,
  input  wire logic [63:0] in_payload_in,
  input  wire logic [31:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic [7:0]       out_category_out,
  output logic [63:0]      out_payload_out,
  output logic [31:0]      out_remaining_time,
  output logic [63:0]      out_audit_sequence,
  output logic [6:0]       out_removed_count,
  output logic [6:0]       out_entry_count
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ttlk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ttlk_dp #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_request_key     (in_request_key),
    .in_item_key        (in_item_key),
    .in_category_in     (in_category_in),
    .in_payload_in      (in_payload_in),
    .in_now_time        (in_now_time),
    .out_found          (out_found),
    .out_category_out   (out_category_out),
    .out_payload_out    (out_payload_out),
    .out_remaining_time (out_remaining_time),
    .out_audit_sequence (out_audit_sequence),
    .out_removed_count  (out_removed_count),
    .out_entry_count    (out_entry_count)
  );

endmodule
`default_nettype wire
